@@ design/sbvq_pkg.sv @@
// package: types and constants of the shared buffer voq scheduler
`timescale 1ns / 1ps
`default_nettype none
package sbvq_pkg;
  localparam int NumEgress  = 8;
  localparam int NumIngress = 8;
  localparam int NumClasses = 3;
  localparam int QueueDepth = 16;
  localparam int EgW  = $clog2(NumEgress);
  localparam int InW  = $clog2(NumIngress);
  localparam int PosW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int NumQueues = NumEgress * NumClasses * NumIngress;
  localparam int QW   = $clog2(NumQueues);
  localparam int NumRr = NumEgress * NumClasses;
  localparam int RrW  = $clog2(NumRr);
  localparam int EntW = 30;

  localparam logic [1:0] ModeArrive   = 2'd0;
  localparam logic [1:0] ModeComplete = 2'd1;
  localparam logic [1:0] ModeRead     = 2'd2;
  localparam logic [1:0] ModeUnused   = 2'd3;

  localparam logic [1:0] VerdictNone  = 2'd0;
  localparam logic [1:0] VerdictAdmit = 2'd1;
  localparam logic [1:0] VerdictDrop  = 2'd2;

  typedef enum logic [2:0] {
    StAdmPkts  = 3'd0,
    StAdmBytes = 3'd1,
    StDrpPkts  = 3'd2,
    StDrpBytes = 3'd3,
    StDeqPkts  = 3'd4,
    StDeqBytes = 3'd5
  } stat_sel_e;

  typedef enum logic [2:0] {
    SIdle,
    SPush,
    SPop,
    SFetch,
    SOut
  } state_e;

  typedef struct packed {
    logic          we;
    logic [QW-1:0] waddr;
    logic [PosW-1:0] wpos;
    logic [EntW-1:0] wdata;
    logic          re;
    logic [QW-1:0] raddr;
    logic [PosW-1:0] rpos;
  } ent_req_t;

  typedef struct packed {
    logic [PosW-1:0] head;
    logic [CntW-1:0] cnt;
  } ptr_t;

  function automatic logic [QW-1:0] queue_index(logic [EgW-1:0] e, logic [1:0] c,
                                                logic [InW-1:0] i);
    return QW'((32'(e) * NumClasses + 32'(c)) * NumIngress + 32'(i));
  endfunction
endpackage
`default_nettype wire

@@ design/shared_buffer_voq_scheduler_top.sv @@
// top level: shared buffer admission, voq bookkeeping and egress dispatch
//
// channel | direction | handshake               | payload
// in      | input     | in_valid_i/in_stall_o   | mode, tag, bytes, ports, prio, select
// out     | output    | out_valid_o/out_stall_i | verdict, dispatch, levels, counter
// cfg     | input     | cfg_we_i                | cfg_wdata_i (buffer_capacity)
//
// a beat is taken only in idle; the accepting edge reads the pointer memory, then
// the push state pushes, the pop state reads the entry memory and the fetch state
// loads the result register, shown in the out state; the next beat is taken the
// cycle after the result beat leaves, and out_stall_i holds the result in out.
// reset clears control and bookkeeping registers; a pointer entry counts only
// while its nonempty bit is set, so neither memory is cleared.
`timescale 1ns / 1ps
`default_nettype none
module shared_buffer_voq_scheduler_top
  import sbvq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [15:0] packet_tag_i,
  input  wire logic [13:0] packet_bytes_i,
  input  wire logic [2:0]  ingress_port_i,
  input  wire logic [2:0]  egress_port_i,
  input  wire logic [1:0]  prio_i,
  input  wire logic [2:0]  counter_select_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       verdict_o,
  output logic             dispatch_valid_o,
  output logic [2:0]       dispatch_egress_o,
  output logic [15:0]      dispatch_tag_o,
  output logic [13:0]      dispatch_bytes_o,
  output logic [23:0]      occupancy_o,
  output logic [23:0]      high_watermark_o,
  output logic [23:0]      egress_backlog_o,
  output logic [47:0]      counter_value_o
);
  state_e state_q, state_d;
  logic [23:0] cap_q, occ_q, peak_q;
  logic [23:0] eg_bytes_q [NumEgress];
  logic [NumEgress-1:0] busy_q;
  logic [NumQueues-1:0] ne_q;
  logic [InW-1:0] last_q [NumRr];
  logic [NumRr-1:0] flag_q;
  logic [47:0] stat_q [6];

  // head and count per queue
  ptr_t ptr_mem [NumQueues];
  ptr_t ptr_a_q, ptr_b_q;
  ptr_t ptr_a, ptr_b;
  logic ptr_we;
  logic [QW-1:0] ptr_waddr;
  ptr_t ptr_wdata;

  // captured beat
  logic [1:0]  mode_q;
  logic [15:0] tag_q;
  logic [13:0] bytes_q;
  logic [2:0]  eg_q, sel_q;
  logic [QW-1:0] qa_q, pq_q;
  logic [RrW-1:0] prr_q;
  logic [InW-1:0] pk_ing_q;
  logic        cand_q, sched_q;
  // pending dispatch
  logic        dsp_q;
  logic [PosW-1:0] pop_head_q;
  logic [CntW-1:0] pop_cnt_q, pop_cnt;

  logic [1:0]  verdict_q;
  logic        ov_valid_q;
  logic        o_dv_q;
  logic [2:0]  o_de_q;
  logic [15:0] o_tag_q;
  logic [13:0] o_bytes_q;
  logic [47:0] o_cv_q;
  logic [23:0] backlog;

  logic [EntW-1:0] rdata;
  ent_req_t req;

  wire acc = in_valid_i && !in_stall_o;
  wire [EgW-1:0] eg_a = EgW'(egress_port_i);
  wire [InW-1:0] in_a = InW'(ingress_port_i);
  wire eg_ok_a = 32'(egress_port_i) < NumEgress;
  wire in_ok_a = 32'(ingress_port_i) < NumIngress;
  wire [1:0] cls_a = (prio_i == 2'd0) ? 2'd0 : (prio_i == 2'd1) ? 2'd1 : 2'd2;
  wire [QW-1:0] q_a = queue_index(eg_a, cls_a, in_a);

  wire fit = {10'd0, packet_bytes_i} <= cap_q &&
             occ_q <= cap_q - {10'd0, packet_bytes_i};
  // a full ring is already nonempty, so the pick does not need the room check
  wire cand_a = mode_i == ModeArrive && eg_ok_a && in_ok_a && fit;

  logic [NumClasses*NumIngress-1:0] ne;
  logic [NumClasses-1:0] fl;
  logic [NumClasses*InW-1:0] ls;
  logic pk_found;
  logic [1:0] pk_cls;
  logic [InW-1:0] pk_ing;
  always_comb begin
    for (int c = 0; c < NumClasses; c++) begin
      fl[c] = flag_q[32'(eg_a) * NumClasses + c];
      ls[c*InW +: InW] = last_q[32'(eg_a) * NumClasses + c];
      for (int i = 0; i < NumIngress; i++) begin
        ne[c*NumIngress + i] = ne_q[queue_index(eg_a, 2'(c), InW'(i))] ||
          (cand_a && cls_a == 2'(c) && in_a == InW'(i));
      end
    end
  end
  sbvq_picker u_picker (
    .nonempty_i(ne), .flag_i(fl), .last_i(ls),
    .found_o(pk_found), .cls_o(pk_cls), .ing_o(pk_ing)
  );
  wire [QW-1:0] pq = queue_index(eg_a, pk_cls, pk_ing);
  wire [RrW-1:0] prr = RrW'(32'(eg_a) * NumClasses + 32'(pk_cls));
  wire sched_a = eg_ok_a && pk_found &&
                 (mode_i == ModeComplete || (cand_a && !busy_q[eg_a]));

  // pointer memory: both reads at the accepting edge, writes in push and pop
  always_ff @(posedge clk_i) begin
    if (ptr_we) begin
      ptr_mem[ptr_waddr] <= ptr_wdata;
    end
    if (acc) begin
      ptr_a_q <= ptr_mem[q_a];
      ptr_b_q <= ptr_mem[pq];
    end
  end

  always_comb begin
    ptr_a = ne_q[qa_q] ? ptr_a_q : '0;
    ptr_b = ne_q[pq_q] ? ptr_b_q : '0;
  end

  wire room = 32'(ptr_a.cnt) < QueueDepth;
  wire admit = cand_q && room;
  wire do_sched = sched_q && (mode_q != ModeArrive || room);
  wire [PosW-1:0] tail = ptr_a.head + PosW'(ptr_a.cnt);
  wire [23:0] occ_add = occ_q + {10'd0, bytes_q};

  always_comb begin
    pop_cnt = (pq_q == qa_q && admit) ? ptr_b.cnt + CntW'(1) : ptr_b.cnt;
  end

  always_comb begin
    ptr_we    = 1'b0;
    ptr_waddr = qa_q;
    ptr_wdata = '0;
    if (state_q == SPush && admit) begin
      ptr_we         = 1'b1;
      ptr_waddr      = qa_q;
      ptr_wdata.head = ptr_a.head;
      ptr_wdata.cnt  = ptr_a.cnt + CntW'(1);
    end else if (state_q == SPop && dsp_q) begin
      ptr_we         = 1'b1;
      ptr_waddr      = pq_q;
      ptr_wdata.head = pop_head_q + PosW'(1);
      ptr_wdata.cnt  = pop_cnt_q - CntW'(1);
    end
  end

  always_comb begin
    req = '0;
    req.we    = state_q == SPush && admit;
    req.waddr = qa_q;
    req.wpos  = tail;
    req.wdata = {bytes_q, tag_q};
    req.re    = state_q == SPop && dsp_q;
    req.raddr = pq_q;
    req.rpos  = pop_head_q;
  end

  sbvq_entry_ram u_ram (.clk_i(clk_i), .req_i(req), .rdata_o(rdata));

  wire [13:0] rd_bytes = rdata[29:16];

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (acc) state_d = SPush;
      SPush:   state_d = SPop;
      SPop:    state_d = SFetch;
      SFetch:  state_d = SOut;
      SOut:    if (!out_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end
  assign in_stall_o = state_q != SIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      cap_q      <= 24'd1048576;
      occ_q      <= '0;
      peak_q     <= '0;
      busy_q     <= '0;
      ne_q       <= '0;
      flag_q     <= '0;
      dsp_q      <= 1'b0;
      ov_valid_q <= 1'b0;
      mode_q     <= '0;
      tag_q      <= '0;
      bytes_q    <= '0;
      eg_q       <= '0;
      sel_q      <= '0;
      qa_q       <= '0;
      pq_q       <= '0;
      prr_q      <= '0;
      pk_ing_q   <= '0;
      cand_q     <= 1'b0;
      sched_q    <= 1'b0;
      pop_head_q <= '0;
      pop_cnt_q  <= '0;
      verdict_q  <= VerdictNone;
      o_dv_q     <= 1'b0;
      o_de_q     <= '0;
      o_tag_q    <= '0;
      o_bytes_q  <= '0;
      o_cv_q     <= '0;
      for (int e = 0; e < NumEgress; e++) eg_bytes_q[e] <= '0;
      for (int r = 0; r < NumRr; r++) last_q[r] <= '0;
      for (int s = 0; s < 6; s++) stat_q[s] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      case (state_q)
        SIdle: if (acc) begin
          mode_q   <= mode_i;
          tag_q    <= packet_tag_i;
          bytes_q  <= packet_bytes_i;
          eg_q     <= egress_port_i;
          sel_q    <= counter_select_i;
          qa_q     <= q_a;
          pq_q     <= pq;
          prr_q    <= prr;
          pk_ing_q <= pk_ing;
          cand_q   <= cand_a;
          sched_q  <= sched_a;
          if (mode_i == ModeComplete && eg_ok_a) busy_q[eg_a] <= 1'b0;
        end
        SPush: begin
          dsp_q      <= do_sched;
          pop_head_q <= ptr_b.head;
          pop_cnt_q  <= pop_cnt;
          verdict_q  <= (mode_q != ModeArrive) ? VerdictNone :
                        admit ? VerdictAdmit : VerdictDrop;
          if (mode_q == ModeArrive) begin
            if (admit) begin
              ne_q[qa_q] <= 1'b1;
              occ_q  <= occ_add;
              peak_q <= (occ_add > peak_q) ? occ_add : peak_q;
              eg_bytes_q[EgW'(eg_q)] <= eg_bytes_q[EgW'(eg_q)] + {10'd0, bytes_q};
              stat_q[StAdmPkts]  <= stat_q[StAdmPkts] + 48'd1;
              stat_q[StAdmBytes] <= stat_q[StAdmBytes] + {34'd0, bytes_q};
            end else begin
              stat_q[StDrpPkts]  <= stat_q[StDrpPkts] + 48'd1;
              stat_q[StDrpBytes] <= stat_q[StDrpBytes] + {34'd0, bytes_q};
            end
          end
          if (do_sched) begin
            flag_q[prr_q] <= 1'b1;
            last_q[prr_q] <= pk_ing_q;
            busy_q[EgW'(eg_q)] <= 1'b1;
          end
        end
        SPop: begin
          if (dsp_q && pop_cnt_q == CntW'(1)) ne_q[pq_q] <= 1'b0;
        end
        // memory data arrives: load the result registers and account the dispatched bytes
        SFetch: begin
          ov_valid_q <= 1'b1;
          o_dv_q    <= dsp_q;
          o_de_q    <= dsp_q ? eg_q : 3'd0;
          o_tag_q   <= dsp_q ? rdata[15:0] : 16'd0;
          o_bytes_q <= dsp_q ? rd_bytes : 14'd0;
          o_cv_q    <= (mode_q == ModeRead && sel_q < 3'd6) ? stat_q[sel_q] : 48'd0;
          if (dsp_q) begin
            occ_q <= occ_q - {10'd0, rd_bytes};
            eg_bytes_q[EgW'(eg_q)] <= eg_bytes_q[EgW'(eg_q)] - {10'd0, rd_bytes};
            stat_q[StDeqPkts]  <= stat_q[StDeqPkts] + 48'd1;
            stat_q[StDeqBytes] <= stat_q[StDeqBytes] + {34'd0, rd_bytes};
          end
        end
        SOut: begin
          if (!out_stall_i) ov_valid_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    backlog = 32'(eg_q) < NumEgress ? eg_bytes_q[EgW'(eg_q)] : 24'd0;
  end

  assign out_valid_o       = ov_valid_q;
  assign verdict_o         = verdict_q;
  assign dispatch_valid_o  = o_dv_q;
  assign dispatch_egress_o = o_de_q;
  assign dispatch_tag_o    = o_tag_q;
  assign dispatch_bytes_o  = o_bytes_q;
  assign occupancy_o       = occ_q;
  assign high_watermark_o  = peak_q;
  assign egress_backlog_o  = backlog;
  assign counter_value_o   = o_cv_q;

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == SOut) else $error("result valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> state_q == SPush) else $error("accepted beat did not start a push");
  a_disp_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == VerdictDrop) |-> !dispatch_valid_o)
    else $error("dispatch on a dropped arrival");
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy_o <= high_watermark_o || !out_valid_o) else $error("occupancy above watermark");
endmodule
`default_nettype wire

@@ design/sbvq_entry_ram.sv @@
// queue entry memory: one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module sbvq_entry_ram
  import sbvq_pkg::*;
(
  input  wire logic            clk_i,
  input  wire ent_req_t        req_i,
  output logic [EntW-1:0]      rdata_o
);
  localparam int Depth = NumQueues * QueueDepth;
  logic [EntW-1:0] mem [Depth];
  logic [EntW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[{req_i.waddr, req_i.wpos}] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[{req_i.raddr, req_i.rpos}];
    end
  end
  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ design/sbvq_picker.sv @@
// round robin and strict priority pick of the next queue of one egress
`timescale 1ns / 1ps
`default_nettype none
module sbvq_picker
  import sbvq_pkg::*;
(
  input  wire logic [NumClasses*NumIngress-1:0] nonempty_i,
  input  wire logic [NumClasses-1:0]            flag_i,
  input  wire logic [NumClasses*InW-1:0]        last_i,
  output logic                                  found_o,
  output logic [1:0]                            cls_o,
  output logic [InW-1:0]                        ing_o
);
  always_comb begin
    logic [InW-1:0] start;
    logic [InW-1:0] idx;
    logic           hit;
    found_o = 1'b0;
    cls_o   = '0;
    ing_o   = '0;
    for (int c = NumClasses - 1; c >= 0; c--) begin
      start = flag_i[c] ? InW'((32'(last_i[c*InW +: InW]) + 1) % NumIngress) : '0;
      hit = 1'b0;
      idx = '0;
      for (int k = NumIngress - 1; k >= 0; k--) begin
        if (nonempty_i[c*NumIngress + 32'((32'(start) + k) % NumIngress)]) begin
          hit = 1'b1;
          idx = InW'((32'(start) + k) % NumIngress);
        end
      end
      if (hit) begin
        found_o = 1'b1;
        cls_o   = 2'(c);
        ing_o   = idx;
      end
    end
  end
endmodule
`default_nettype wire
